// ----- src/mtw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-task watchdog package
// Sizes, operation and status codes, and the records passed between the
// sequencer and the slot evaluation unit.
// ----------------------------------------------------------------------------
package mtw_pkg;

    localparam int SLOTS            = 16;
    localparam int TICKS_PER_SECOND = 100;

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OP_W    = 2;
    localparam int TASK_W  = 5;
    localparam int LIFE_W  = 16;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 8;
    localparam int STAT_W  = 2;
    localparam int FAIL_W  = 1 << TASK_W;

    localparam int TPS_W   = $clog2(TICKS_PER_SECOND + 1);
    localparam int TICKS_W = LIFE_W + TPS_W;
    localparam int CMP_W   = (TICKS_W > TIME_W) ? TICKS_W : TIME_W;

    localparam int S_TDATA_W = ((TASK_W + LIFE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((STAT_W + FAIL_W + 1 + 7) / 8) * 8;

    localparam logic [TPS_W-1:0]   TPS_VAL       = TPS_W'(TICKS_PER_SECOND);
    localparam logic [IDX_W-1:0]   LAST_IDX      = IDX_W'(SLOTS - 1);
    localparam logic [COUNT_W-1:0] MISS_SATURATE = 8'hFF;
    localparam logic [COUNT_W-1:0] MISS_LIMIT_RST = 8'd3;

    localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
    localparam logic [OP_W-1:0] OP_KICK     = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK    = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK     = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic               vld;
        logic [IDX_W-1:0]   idx;
        logic               used;
        logic [TASK_W-1:0]  task_id;
        logic [LIFE_W-1:0]  life;
        logic [TIME_W-1:0]  stamp;
        logic [COUNT_W-1:0] count;
    } slot_rd_t;

    typedef struct packed {
        logic               vld;
        logic [IDX_W-1:0]   idx;
        logic               used;
        logic               free;
        logic               match;
        logic               overdue;
        logic [TASK_W-1:0]  task_id;
        logic [COUNT_W-1:0] new_count;
        logic               at_limit;
    } eval_t;

endpackage
`default_nettype wire

// ----- src/mtw_slot_eval.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot evaluation unit
// Judges one slot per cycle: the lifetime in ticks and the elapsed time are
// registered, then compared, and the slot's next miss count is formed.
// ----------------------------------------------------------------------------
module mtw_slot_eval
    import mtw_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire slot_rd_t           rd,
    input  wire logic [TASK_W-1:0]  req_task,
    input  wire logic [TIME_W-1:0]  time_now,
    input  wire logic [COUNT_W-1:0] miss_limit,
    output eval_t                   ev
);

    logic               s1_vld_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_used_reg;
    logic               s1_match_reg;
    logic [TASK_W-1:0]  s1_task_reg;
    logic [TICKS_W-1:0] s1_ticks_reg;
    logic [TIME_W-1:0]  s1_elapsed_reg;
    logic [COUNT_W-1:0] s1_count_reg;

    logic               overdue;
    logic [COUNT_W-1:0] new_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= rd.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg     <= rd.idx;
        s1_used_reg    <= rd.used;
        s1_match_reg   <= (rd.task_id == req_task);
        s1_task_reg    <= rd.task_id;
        s1_ticks_reg   <= TICKS_W'(rd.life) * TICKS_W'(TPS_VAL);
        s1_elapsed_reg <= time_now - rd.stamp;
        s1_count_reg   <= rd.count;
    end

    always_comb
    begin
        overdue = s1_used_reg && (CMP_W'(s1_elapsed_reg) >= CMP_W'(s1_ticks_reg));
        if (!s1_used_reg)
        begin
            new_count = s1_count_reg;
        end
        else if (overdue)
        begin
            new_count = (s1_count_reg == MISS_SATURATE) ? s1_count_reg
                                                        : s1_count_reg + COUNT_W'(1);
        end
        else
        begin
            new_count = '0;
        end
    end

    assign ev.vld       = s1_vld_reg;
    assign ev.idx       = s1_idx_reg;
    assign ev.used      = s1_used_reg;
    assign ev.free      = !s1_used_reg;
    assign ev.match     = s1_used_reg && s1_match_reg;
    assign ev.overdue   = overdue;
    assign ev.task_id   = s1_task_reg;
    assign ev.new_count = new_count;
    assign ev.at_limit  = (new_count >= miss_limit);

endmodule
`default_nettype wire

// ----- src/multi_task_watchdog.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-task watchdog
// Keeps a table of task slots with lifetimes and kick stamps, a tick counter,
// and answers register, kick, check and tick requests with one result each.
// ----------------------------------------------------------------------------
// A check walks all SLOTS slots through the slot read register and the evaluation
// unit at one slot per cycle; no new request is accepted until the result is in
// the output register. A register stops at the first free slot and a kick at the
// first matching slot; with none, they walk the whole table. A tick skips the walk.
// The result is held in an output register, so one result may wait there.
// Reset frees every slot, clears miss counts and time, and sets miss_limit 3.
module multi_task_watchdog
    import mtw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [COUNT_W-1:0]   cfg_wr_data,   // miss_limit
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,       // task_id, life_seconds, zero pad
    input  wire logic [OP_W-1:0]      s_tuser,       // operation
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata        // status, fail_mask, reboot, zero pad
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0]           state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [TASK_W-1:0]    id_reg, id_next;
    logic [LIFE_W-1:0]    life_reg, life_next;
    logic [TIME_W-1:0]    time_now_reg, time_now_next;
    logic [COUNT_W-1:0]   miss_limit_reg;
    logic                 issue_on_reg, issue_on_next;
    logic [IDX_W-1:0]     issue_idx_reg, issue_idx_next;
    logic [STAT_W-1:0]    status_reg, status_next;
    logic [FAIL_W-1:0]    fail_acc_reg, fail_acc_next;
    logic                 reboot_acc_reg, reboot_acc_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic [SLOTS-1:0]     slot_used_reg;
    logic [COUNT_W-1:0]   miss_count_reg [SLOTS];
    logic [TASK_W-1:0]    slot_task_mem [SLOTS];
    logic [LIFE_W-1:0]    slot_life_mem [SLOTS];
    logic [TIME_W-1:0]    slot_stamp_mem [SLOTS];

    logic                 rd_vld_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_used_reg;
    logic [TASK_W-1:0]    rd_task_reg;
    logic [LIFE_W-1:0]    rd_life_reg;
    logic [TIME_W-1:0]    rd_stamp_reg;
    logic [COUNT_W-1:0]   rd_count_reg;

    logic                 accept;
    logic                 issue;
    logic                 slot_wr;
    logic                 stamp_wr;
    logic                 count_wr;
    logic [COUNT_W-1:0]   count_wdata;
    logic                 finish;
    slot_rd_t             rd;
    eval_t                ev;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign issue    = (state_reg == ST_SCAN) && issue_on_reg;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign rd.vld     = rd_vld_reg;
    assign rd.idx     = rd_idx_reg;
    assign rd.used    = rd_used_reg;
    assign rd.task_id = rd_task_reg;
    assign rd.life    = rd_life_reg;
    assign rd.stamp   = rd_stamp_reg;
    assign rd.count   = rd_count_reg;

    mtw_slot_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd         (rd),
        .req_task   (id_reg),
        .time_now   (time_now_reg),
        .miss_limit (miss_limit_reg),
        .ev         (ev)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        life_next       = life_reg;
        time_now_next   = time_now_reg;
        issue_on_next   = issue_on_reg;
        issue_idx_next  = issue_idx_reg;
        status_next     = status_reg;
        fail_acc_next   = fail_acc_reg;
        reboot_acc_next = reboot_acc_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        slot_wr         = 1'b0;
        stamp_wr        = 1'b0;
        count_wr        = 1'b0;
        count_wdata     = '0;
        finish          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = s_tuser;
                    id_next         = s_tdata[TASK_W-1:0];
                    life_next       = s_tdata[TASK_W+LIFE_W-1:TASK_W];
                    status_next     = STAT_OK;
                    fail_acc_next   = '0;
                    reboot_acc_next = 1'b0;
                    if (s_tuser == OP_TICK)
                    begin
                        time_now_next = time_now_reg + TIME_W'(1);
                        state_next    = ST_RESULT;
                    end
                    else
                    begin
                        issue_on_next  = 1'b1;
                        issue_idx_next = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (issue_on_reg)
                begin
                    if (issue_idx_reg == LAST_IDX)
                    begin
                        issue_on_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + IDX_W'(1);
                    end
                end
                if (ev.vld)
                begin
                    unique case (op_reg)
                        OP_REGISTER:
                        begin
                            if (ev.free)
                            begin
                                slot_wr  = 1'b1;
                                stamp_wr = 1'b1;
                                count_wr = 1'b1;
                                finish   = 1'b1;
                            end
                            else if (ev.idx == LAST_IDX)
                            begin
                                status_next = STAT_FULL;
                                finish      = 1'b1;
                            end
                        end
                        OP_KICK:
                        begin
                            if (ev.match)
                            begin
                                stamp_wr = 1'b1;
                                finish   = 1'b1;
                            end
                            else if (ev.idx == LAST_IDX)
                            begin
                                status_next = STAT_NOT_FOUND;
                                finish      = 1'b1;
                            end
                        end
                        OP_CHECK:
                        begin
                            if (ev.used)
                            begin
                                count_wr    = 1'b1;
                                count_wdata = ev.new_count;
                                if (ev.overdue)
                                begin
                                    fail_acc_next = fail_acc_reg
                                                  | (FAIL_W'(1) << ev.task_id);
                                end
                                else
                                begin
                                    stamp_wr = 1'b1;
                                end
                            end
                            reboot_acc_next = reboot_acc_reg || ev.at_limit;
                            finish          = (ev.idx == LAST_IDX);
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
                if (finish)
                begin
                    issue_on_next = 1'b0;
                    state_next    = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({reboot_acc_reg, fail_acc_reg, status_reg});
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            time_now_reg   <= '0;
            miss_limit_reg <= MISS_LIMIT_RST;
            issue_on_reg   <= 1'b0;
            issue_idx_reg  <= '0;
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            slot_used_reg  <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                miss_count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            time_now_reg  <= time_now_next;
            issue_on_reg  <= issue_on_next;
            issue_idx_reg <= issue_idx_next;
            rd_vld_reg    <= issue;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                miss_limit_reg <= cfg_wr_data;
            end
            if (slot_wr)
            begin
                slot_used_reg[ev.idx] <= 1'b1;
            end
            if (count_wr)
            begin
                miss_count_reg[ev.idx] <= count_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        life_reg       <= life_next;
        status_reg     <= status_next;
        fail_acc_reg   <= fail_acc_next;
        reboot_acc_reg <= reboot_acc_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_ff @(posedge clk)
    begin
        if (slot_wr)
        begin
            slot_task_mem[ev.idx] <= id_reg;
            slot_life_mem[ev.idx] <= life_reg;
        end
        if (stamp_wr)
        begin
            slot_stamp_mem[ev.idx] <= time_now_reg;
        end
        rd_idx_reg   <= issue_idx_reg;
        rd_used_reg  <= slot_used_reg[issue_idx_reg];
        rd_count_reg <= miss_count_reg[issue_idx_reg];
        rd_task_reg  <= slot_task_mem[issue_idx_reg];
        rd_life_reg  <= slot_life_mem[issue_idx_reg];
        rd_stamp_reg <= slot_stamp_mem[issue_idx_reg];
    end

`ifndef SYNTHESIS
    a_idle_pipe_empty : assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !rd_vld_reg)
        else $error("Slot read stage holds work while a new request may be accepted.");

    a_scan_index_range : assert property (@(posedge clk) disable iff (!rst_n)
        issue_on_reg |-> (issue_idx_reg <= LAST_IDX))
        else $error("Slot walk has run past the last slot.");

    a_check_only_fails : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && op_reg != OP_CHECK)
            |-> (fail_acc_reg == '0 && !reboot_acc_reg))
        else $error("Fail mask or reboot raised outside a check.");

    a_tick_advances : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == OP_TICK) |=> (time_now_reg == $past(time_now_reg) + TIME_W'(1)))
        else $error("Tick request did not advance time by one.");

    a_slots_stay_used : assert property (@(posedge clk) disable iff (!rst_n)
        (slot_used_reg != '0) |=> (slot_used_reg != '0))
        else $error("A used slot has been freed.");
`endif

endmodule
`default_nettype wire

// ----- test/multi_task_watchdog_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-task watchdog testbench
// Drives register, kick, check and tick requests into the watchdog with random
// gaps and output stalls. Each reply is checked against the plan's expected reply
// or a predictor of the slot table, tick counter and miss counts. The miss limit
// is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module multi_task_watchdog_test
    import mtw_pkg::*;
();

    localparam int PLAN_LEN     = 17;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 239;
    localparam int LONG_STALL   = 300;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FAIL_W-1:0] fail_mask;
        logic              reboot;
    } wd_reply_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TASK_W-1:0] task_id;
        logic [LIFE_W-1:0] life;
        logic              typed;
        wd_reply_t         want;
    } plan_row_t;

    localparam wd_reply_t NO_REPLY = '0;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [COUNT_W-1:0]   cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [OP_W-1:0]      s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    logic               slot_busy  [SLOTS];
    logic [TASK_W-1:0]  slot_owner [SLOTS];
    logic [LIFE_W-1:0]  slot_life  [SLOTS];
    logic [TIME_W-1:0]  slot_kick  [SLOTS];
    logic [COUNT_W-1:0] slot_miss  [SLOTS];
    logic [TIME_W-1:0]  tick_now;
    logic [COUNT_W-1:0] miss_limit_now;

    wd_reply_t awaited_replies [$];
    plan_row_t plan [PLAN_LEN];

    int  mismatch_count = 0;
    int  cycle_count    = 0;
    int  requests_sent  = 0;
    int  checks_sent    = 0;
    int  overdue_checks = 0;
    int  reboot_checks  = 0;
    int  full_refusals  = 0;
    int  unknown_kicks  = 0;
    bit  sender_calm    = 1'b0;
    bit  receiver_calm  = 1'b0;
    bit  long_stall_req = 1'b0;

    multi_task_watchdog u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d replies outstanding", cycle_count,
                 awaited_replies.size());
        $display("Mismatches found");
        $finish;
    end

    function automatic void clear_watchdog_state();
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_busy[i]  = 1'b0;
            slot_owner[i] = '0;
            slot_life[i]  = '0;
            slot_kick[i]  = '0;
            slot_miss[i]  = '0;
        end
        tick_now       = '0;
        miss_limit_now = MISS_LIMIT_RST;
    endfunction

    function automatic wd_reply_t predict_reply(input logic [OP_W-1:0] op,
                                                input logic [TASK_W-1:0] id,
                                                input logic [LIFE_W-1:0] life);
        wd_reply_t  r;
        logic [47:0] span;
        logic [TIME_W-1:0] elapsed;
        bit done;
        r = '0;
        done = 1'b0;
        case (op)
            OP_REGISTER:
            begin
                r.status = STAT_FULL;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!done && !slot_busy[i])
                    begin
                        slot_busy[i]  = 1'b1;
                        slot_owner[i] = id;
                        slot_life[i]  = life;
                        slot_kick[i]  = tick_now;
                        slot_miss[i]  = '0;
                        r.status = STAT_OK;
                        done = 1'b1;
                    end
                end
            end
            OP_KICK:
            begin
                r.status = STAT_NOT_FOUND;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!done && slot_busy[i] && slot_owner[i] == id)
                    begin
                        slot_kick[i] = tick_now;
                        r.status = STAT_OK;
                        done = 1'b1;
                    end
                end
            end
            OP_CHECK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_busy[i])
                    begin
                        span    = 48'(slot_life[i]) * 48'(TICKS_PER_SECOND);
                        elapsed = tick_now - slot_kick[i];
                        if (48'(elapsed) >= span)
                        begin
                            r.fail_mask[slot_owner[i]] = 1'b1;
                            if (slot_miss[i] < MISS_SATURATE)
                                slot_miss[i] = slot_miss[i] + 1'b1;
                        end
                        else
                        begin
                            slot_kick[i] = tick_now;
                            slot_miss[i] = '0;
                        end
                    end
                end
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (slot_miss[i] >= miss_limit_now)
                        r.reboot = 1'b1;
                end
            end
            default:
            begin
                tick_now = tick_now + 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic logic [TASK_W-1:0] known_id();
        int n;
        int pick;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_busy[i])
                n++;
        end
        if (n == 0)
            return TASK_W'($urandom);
        pick = $urandom_range(0, n - 1);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_busy[i])
            begin
                if (pick == 0)
                    return slot_owner[i];
                pick--;
            end
        end
        return '0;
    endfunction

    task automatic send_request(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] id,
                                input logic [LIFE_W-1:0] life, input logic typed,
                                input wd_reply_t want);
        int gap;
        wd_reply_t guess;
        if ($urandom_range(0, 39) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({life, id});
        do @(posedge clk); while (!s_tready);
        guess = predict_reply(op, id, life);
        awaited_replies.push_back(typed ? want : guess);
        requests_sent++;
        if (op == OP_CHECK)
            checks_sent++;
        if (guess.fail_mask != '0)
            overdue_checks++;
        if (guess.reboot)
            reboot_checks++;
        if (guess.status == STAT_FULL)
            full_refusals++;
        if (guess.status == STAT_NOT_FOUND)
            unknown_kicks++;
    endtask

    task automatic drain_replies();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_miss_limit(input logic [COUNT_W-1:0] value);
        drain_replies();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        miss_limit_now = value;
    endtask

    // Mostly short mixed bursts heavy in checks, with some long runs of ticks
    // so that tasks with a lifetime of one second actually fall overdue.
    task automatic random_requests(input int count);
        int sent;
        int len;
        int r;
        logic [OP_W-1:0]   op;
        logic [TASK_W-1:0] id;
        logic [LIFE_W-1:0] life;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                len = $urandom_range(100, 160);
                if (len > count - sent - 1)
                    len = count - sent - 1;
                for (int j = 0; j < len; j++)
                begin
                    op = ($urandom_range(0, 29) == 0) ? OP_KICK : OP_TICK;
                    send_request(op, known_id(), LIFE_W'($urandom), 1'b0, NO_REPLY);
                end
                send_request(OP_CHECK, TASK_W'($urandom), LIFE_W'($urandom), 1'b0,
                             NO_REPLY);
                sent += len + 1;
            end
            else
            begin
                len = $urandom_range(20, 40);
                if (len > count - sent)
                    len = count - sent;
                for (int j = 0; j < len; j++)
                begin
                    r  = $urandom_range(0, 99);
                    op = (r < 6) ? OP_REGISTER : (r < 26) ? OP_KICK :
                         (r < 81) ? OP_CHECK : OP_TICK;
                    id = (op == OP_KICK && $urandom_range(0, 3) != 0) ?
                         known_id() : TASK_W'($urandom);
                    life = LIFE_W'($urandom);
                    if (op == OP_REGISTER)
                    begin
                        r = $urandom_range(0, 19);
                        if (r < 2)
                            life = '0;
                        else if (r < 12)
                            life = LIFE_W'($urandom_range(1, 3));
                        else if (r < 14)
                            life = '1;
                    end
                    send_request(op, id, life, 1'b0, NO_REPLY);
                end
                sent += len;
            end
        end
    endtask

    initial
    begin
        int gap;
        int held;
        wd_reply_t want;
        wd_reply_t seen;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (long_stall_req)
            begin
                long_stall_req = 1'b0;
                m_tready <= 1'b0;
                held = 0;
                while (held < LONG_STALL)
                begin
                    @(negedge clk);
                    held++;
                end
            end
            else
            begin
                if ($urandom_range(0, 39) == 0)
                    receiver_calm = !receiver_calm;
                gap = receiver_calm ? 0 : $urandom_range(0, 10);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            seen = {m_tdata[1:0], m_tdata[33:2], m_tdata[34]};
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: unexpected reply, expected none, got status %0d mask %h",
                         $time, seen.status, seen.fail_mask);
                $display("%0t: unexpected reply carries reboot %0d", $time, seen.reboot);
                mismatch_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (seen.status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status,
                             seen.status);
                    mismatch_count++;
                end
                if (seen.fail_mask !== want.fail_mask)
                begin
                    $display("%0t: fail mask expected %h, got %h", $time, want.fail_mask,
                             seen.fail_mask);
                    mismatch_count++;
                end
                if (seen.reboot !== want.reboot)
                begin
                    $display("%0t: reboot expected %0d, got %0d", $time, want.reboot,
                             seen.reboot);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        logic [COUNT_W-1:0] limits [PHASES];
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_REGISTER;
        clear_watchdog_state();
        limits = '{8'd0, 8'd1, 8'd255, COUNT_W'($urandom_range(4, 254)), 8'd2, 8'd255};
        plan = '{
            {OP_CHECK,    5'd0,  16'd0,     1'b1, STAT_OK,        32'h0,         1'b0},
            {OP_KICK,     5'd5,  16'd0,     1'b1, STAT_NOT_FOUND, 32'h0,         1'b0},
            {OP_TICK,     5'd31, 16'hFFFF,  1'b1, STAT_OK,        32'h0,         1'b0},
            {OP_REGISTER, 5'd0,  16'hFFFF,  1'b1, STAT_OK,        32'h0,         1'b0},
            {OP_REGISTER, 5'd31, 16'd0,     1'b1, STAT_OK,        32'h0,         1'b0},
            {OP_REGISTER, 5'd31, 16'd1,     1'b1, STAT_OK,        32'h0,         1'b0},
            {OP_REGISTER, 5'd7,  16'd1,     1'b1, STAT_OK,        32'h0,         1'b0},
            {OP_CHECK,    5'd0,  16'd0,     1'b1, STAT_OK,        32'h8000_0000, 1'b0},
            {OP_KICK,     5'd31, 16'd0,     1'b1, STAT_OK,        32'h0,         1'b0},
            {OP_CHECK,    5'd0,  16'd0,     1'b0, NO_REPLY},
            {OP_CHECK,    5'd0,  16'd0,     1'b0, NO_REPLY},
            {OP_KICK,     5'd12, 16'd0,     1'b1, STAT_NOT_FOUND, 32'h0,         1'b0},
            {OP_REGISTER, 5'd20, 16'd2,     1'b1, STAT_OK,        32'h0,         1'b0},
            {OP_TICK,     5'd0,  16'd0,     1'b1, STAT_OK,        32'h0,         1'b0},
            {OP_KICK,     5'd7,  16'h5A5A,  1'b0, NO_REPLY},
            {OP_CHECK,    5'd31, 16'hFFFF,  1'b0, NO_REPLY},
            {OP_REGISTER, 5'd16, 16'h8000,  1'b0, NO_REPLY}
        };
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int k = 0; k < PLAN_LEN; k++)
            send_request(plan[k].op, plan[k].task_id, plan[k].life, plan[k].typed,
                         plan[k].want);

        for (int p = 0; p < PHASES; p++)
        begin
            set_miss_limit(limits[p]);
            if (p == 2)
            begin
                @(posedge clk);
                long_stall_req = 1'b1;
                sender_calm    = 1'b1;
            end
            random_requests(PHASE_ITEMS);
        end

        drain_replies();
        repeat (25) @(posedge clk);

        $display("Covered %0d requests including %0d checks; %0d replies flagged",
                 requests_sent, checks_sent, overdue_checks);
        $display("overdue tasks and %0d raised reboot; %0d registrations refused on a full",
                 reboot_checks, full_refusals);
        $display("table and %0d kicks for unknown tasks.", unknown_kicks);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
